// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk in the using scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define KWI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define KWI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/kwi_pkg.sv
// ---------------------------------------------------------------------------
// kwi_pkg
// Constants and controller/datapath link types for the keyframe interpolator.
// ---------------------------------------------------------------------------
package kwi_pkg;

  localparam int GAP_DEPTH = 63;
  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = $clog2(GAP_DEPTH + 1);
  localparam int ADDR_W    = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
  localparam int DVSR_W    = CNT_W + 1;
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [SAMPLE_W-1:0] HALF_SPAN = SAMPLE_W'(1) << (SAMPLE_W - 1);

  // commands, controller to datapath
  typedef struct packed {
    logic accept;     // capture the input beat
    logic store;      // write sample into the gap store
    logic set_mode;   // latch result flags, clear emit index
    logic mode_interp;
    logic mode_ovf;
    logic div_start;  // load divider and accumulator
    logic div_step;
    logic rd;         // read gap store at emit index
    logic emit_gap;   // load output with a gap frame
    logic emit_last;  // load output with the captured sample, close the item
  } kwi_cmd_t;

  // status, datapath to controller
  typedef struct packed {
    logic seen;
    logic key;
    logic fin;
    logic cnt_zero;
    logic cnt_full;
    logic div_last;
    logic emit_last;
    logic out_free;
  } kwi_sts_t;

endpackage

// File: rtl/kwi_ram.sv
// ---------------------------------------------------------------------------
// kwi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kwi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/kwi_ctrl.sv
// ---------------------------------------------------------------------------
// kwi_ctrl
// Sequencer: classifies each frame and steps divide, flush and emit phases.
// ---------------------------------------------------------------------------
module kwi_ctrl
  import kwi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  kwi_sts_t  sts,
  output kwi_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_RD     = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_LAST   = 6'b100000
  } kwi_state_t;

  kwi_state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.set_mode = 1'b1;
        if (!sts.seen) begin
          state_nxt = ST_LAST;
        end else if (sts.key) begin
          cmd.mode_interp = 1'b1;
          cmd.div_start   = 1'b1;
          state_nxt       = ST_DIV;
        end else if (sts.cnt_full) begin
          cmd.mode_ovf = 1'b1;
          state_nxt    = ST_RD;
        end else if (sts.fin) begin
          state_nxt = sts.cnt_zero ? ST_LAST : ST_RD;
        end else begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.cnt_zero ? ST_LAST : ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_gap = 1'b1;
          state_nxt    = sts.emit_last ? ST_LAST : ST_RD;
        end
      end
      ST_LAST: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/kwi_dpath.sv
// ---------------------------------------------------------------------------
// kwi_dpath
// Anchor and gap state, gap store, serial divider, step accumulator, output.
// ---------------------------------------------------------------------------
module kwi_dpath
  import kwi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  kwi_cmd_t            cmd,
  output kwi_sts_t            sts,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_key,
  input  logic                in_fin,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_value,
  output logic                out_interp,
  output logic                out_ovf,
  output logic                out_last
);

  // captured beat
  logic [SAMPLE_W-1:0] sample_r;
  logic                key_r, fin_r;

  // channel state
  logic [SAMPLE_W-1:0] anchor_r;
  logic                seen_r;
  logic [CNT_W-1:0]    count_r;

  // run state
  logic                interp_r, ovf_r;
  logic [CNT_W-1:0]    idx_r;
  logic [SAMPLE_W-1:0] acc_r;

  // divider
  logic [SAMPLE_W-1:0] quo_r;
  logic [DVSR_W-1:0]   rem_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic                neg_r;

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic                out_interp_r, out_ovf_r, out_last_r;

  logic [SAMPLE_W-1:0] diff;
  logic                diff_neg;
  logic [SAMPLE_W-1:0] diff_mag;
  logic [DVSR_W-1:0]   dvsr;
  logic [DVSR_W:0]     trial;
  logic                qbit;
  logic [DVSR_W-1:0]   rem_nxt;
  logic [SAMPLE_W-1:0] step;
  logic [SAMPLE_W-1:0] acc_sum;
  logic [SAMPLE_W-1:0] rd_data;

  // shortest wrapped distance; exactly half span is negative only when the
  // new key sits above the anchor
  assign diff     = sample_r - anchor_r;
  assign diff_neg = diff[SAMPLE_W-1] && ((diff != HALF_SPAN) || (sample_r > anchor_r));
  assign diff_mag = diff[SAMPLE_W-1] ? (~diff + SAMPLE_W'(1)) : diff;

  // restoring division of the magnitude by gap count plus one
  assign dvsr    = {1'b0, count_r} + DVSR_W'(1);
  assign trial   = {rem_r, quo_r[SAMPLE_W-1]};
  assign qbit    = (trial >= {1'b0, dvsr});
  assign rem_nxt = qbit ? DVSR_W'(trial - {1'b0, dvsr}) : trial[DVSR_W-1:0];

  assign step    = neg_r ? (~quo_r + SAMPLE_W'(1)) : quo_r;
  assign acc_sum = acc_r + step;

  kwi_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (GAP_DEPTH)
  ) u_gap_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (sample_r),
    .re    (cmd.rd),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      key_r    <= in_key;
      fin_r    <= in_fin;
    end
    if (cmd.set_mode) begin
      interp_r <= cmd.mode_interp;
      ovf_r    <= cmd.mode_ovf;
    end
    if (cmd.div_start) begin
      quo_r  <= diff_mag;
      neg_r  <= diff_neg;
      rem_r  <= '0;
      acc_r  <= anchor_r;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SAMPLE_W-2:0], qbit};
      rem_r <= rem_nxt;
    end else if (cmd.emit_gap) begin
      acc_r <= acc_sum;
    end
    if (cmd.emit_gap) begin
      out_value_r  <= interp_r ? acc_sum : rd_data;
      out_interp_r <= interp_r;
      out_ovf_r    <= ovf_r;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_last) begin
      out_value_r  <= sample_r;
      out_interp_r <= 1'b0;
      out_ovf_r    <= ovf_r;
      out_last_r   <= 1'b1;
    end
    if (cmd.emit_last && key_r) begin
      anchor_r <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.emit_last) begin
        count_r <= '0;
        seen_r  <= key_r && !fin_r;
      end
      if (cmd.set_mode) begin
        idx_r <= '0;
      end else if (cmd.emit_gap) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.div_start) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (cmd.emit_gap || cmd.emit_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.seen      = seen_r;
    sts.key       = key_r;
    sts.fin       = fin_r;
    sts.cnt_zero  = (count_r == '0);
    sts.cnt_full  = (count_r == CNT_W'(GAP_DEPTH));
    sts.div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
    sts.emit_last = ((idx_r + CNT_W'(1)) == count_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_interp = out_interp_r;
  assign out_ovf    = out_ovf_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/keyframe_wrap_interpolator.sv
// Flow: a pass-through frame, or a keyframe with no anchor, goes from the captured beat
//   through the decide and last states to the output register; a keyframe after an
//   anchor first runs the 16-step divider; a buffered frame gives no output.
//   One beat at a time; each gap frame, in a key run or a flush, takes a store read and an emit.
// Reset: synchronous, active low; clears anchor flag, gap count and output valid.
//   The gap store is not cleared, so a beat can be taken right after reset.
// ---------------------------------------------------------------------------
// keyframe_wrap_interpolator
// Fills the frames between two keyframes of a 16-bit wrapping channel by
// linear steps along the shortest arc; frames outside a key pair pass through.
// ---------------------------------------------------------------------------
module keyframe_wrap_interpolator
  import kwi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] is_key
  input  logic        in_tlast,   // final_frame
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] value
  output logic [1:0]  out_tuser,  // [0] was_interpolated, [1] gap_overflow
  output logic        out_tlast   // run_end
);

  kwi_cmd_t cmd;
  kwi_sts_t sts;

  // Controller: one beat at a time, decides pass, hold, flush or interpolate.
  kwi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: anchor, gap store, divider, accumulator and output register.
  // The output register lets the next beat in while a result still waits.
  kwi_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .in_key     (in_tuser),
    .in_fin     (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata[SAMPLE_W-1:0]),
    .out_interp (out_tuser[0]),
    .out_ovf    (out_tuser[1]),
    .out_last   (out_tlast)
  );

endmodule

// File: rtl/kwi_checker.sv
// ---------------------------------------------------------------------------
// kwi_props
// Port-level assertions for the keyframe interpolator, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kwi_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic [18:0] in_word;
  logic [19:0] out_word;
  logic        interp_bad;

  assign in_word    = {in_tvalid, in_tdata, in_tuser, in_tlast};
  assign out_word   = {out_tvalid, out_tdata, out_tuser, out_tlast};
  // an interpolated frame never closes a run and never carries the gap overflow flag
  assign interp_bad = out_tuser[0] && (out_tlast || out_tuser[1]);

  `KWI_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  `KWI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> $stable(out_word), "stalled beat changed")

  `KWI_ASSERT(a_in_hold, in_tvalid && !in_tready |=> $stable(in_word), "input beat changed")

  `KWI_ASSERT(a_one_beat, in_tvalid && in_tready |=> !in_tready, "second beat taken too early")

  `KWI_ASSERT(a_interp_flags, !(out_tvalid && interp_bad), "interpolated beat flags wrong")

endmodule

bind keyframe_wrap_interpolator kwi_props u_kwi_props (.*);
